// File: design/srcls_pkg.sv
// ----------------------------------------------------------------------------
// SSH record classifier package
// Shared types, record kind codes and the header classification function.
// ----------------------------------------------------------------------------
package srcls_pkg;

  localparam int MaxCaptureBytesDefault = 65535;

  localparam int CountWidth  = 16;
  localparam int TdataWidth  = 120;
  localparam int ResultWidth = 115;

  // record kind codes
  localparam logic [1:0] KIND_NOT_SSH = 2'd0;
  localparam logic [1:0] KIND_IDENT   = 2'd1;
  localparam logic [1:0] KIND_BINARY  = 2'd2;

  // "SSH-" and the line terminator
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_H    = 8'h48;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  localparam logic [15:0] IdentPrefixBytes = 16'd4;
  localparam logic [15:0] MinBinaryBytes   = 16'd5;
  localparam logic [31:0] MinRecordLength  = 32'd2;
  localparam logic [7:0]  MinPadLength     = 8'd4;
  localparam logic [32:0] LengthFieldBytes = 33'd4;
  localparam logic [15:0] CrLfBytes        = 16'd2;

  // scan state after the current byte has been taken
  typedef struct packed {
    logic [15:0] byte_count;
    logic [31:0] length_shift;
    logic [7:0]  pad_byte;
    logic [7:0]  type_byte;
    logic        prefix_match;
    logic        line_found;
    logic [15:0] line_length;
  } scan_view_t;

  typedef struct packed {
    logic [15:0] bytes_consumed;
    logic [31:0] body_length;
    logic [7:0]  msg_type;
    logic [7:0]  pad_length;
    logic [31:0] record_length;
    logic [15:0] ident_length;
    logic        parse_error;
    logic [1:0]  record_kind;
  } result_t;

  function automatic result_t classify(input scan_view_t v);
    result_t     r;
    logic [32:0] frame_bytes;
    r           = '0;
    frame_bytes = LengthFieldBytes + {1'b0, v.length_shift};
    if (v.byte_count >= IdentPrefixBytes && v.prefix_match) begin
      r.record_kind = KIND_IDENT;
      if (v.line_found) begin
        r.ident_length   = v.line_length;
        r.bytes_consumed = v.line_length + CrLfBytes;
      end else begin
        r.parse_error = 1'b1;
      end
    end else if (v.byte_count >= MinBinaryBytes &&
                 v.length_shift >= MinRecordLength &&
                 v.pad_byte >= MinPadLength &&
                 {24'd0, v.pad_byte} < v.length_shift &&
                 frame_bytes <= {17'd0, v.byte_count}) begin
      r.record_kind    = KIND_BINARY;
      r.record_length  = v.length_shift;
      r.pad_length     = v.pad_byte;
      r.msg_type       = v.type_byte;
      r.body_length    = v.length_shift - 32'd1 - {24'd0, v.pad_byte};
      r.bytes_consumed = frame_bytes[15:0];
    end
    return r;
  endfunction

endpackage

// File: design/srcls_scan.sv
// ----------------------------------------------------------------------------
// SSH record classifier byte scanner
// Holds the per-packet header and line state and shows it after each byte.
// ----------------------------------------------------------------------------
module srcls_scan #(
  parameter int MAX_CAPTURE_BYTES = srcls_pkg::MaxCaptureBytesDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_capture,
  output srcls_pkg::scan_view_t  view
);
  import srcls_pkg::*;

  localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MAX_CAPTURE_BYTES);

  logic [15:0] byte_count;
  logic [31:0] length_shift;
  logic [7:0]  pad_byte;
  logic [7:0]  type_byte;
  logic        prefix_match;
  logic        saw_cr;
  logic        line_found;
  logic [15:0] line_length;

  logic        saw_cr_next;
  logic        keep;
  logic [7:0]  prefix_char;

  always_comb begin
    unique case (byte_count[1:0])
      2'd0:    prefix_char = CHAR_S;
      2'd1:    prefix_char = CHAR_S;
      2'd2:    prefix_char = CHAR_H;
      default: prefix_char = CHAR_DASH;
    endcase
  end

  // drop bytes once the capture limit is reached
  assign keep = byte_count < CountLimit;

  always_comb begin
    view.byte_count   = byte_count;
    view.length_shift = length_shift;
    view.pad_byte     = pad_byte;
    view.type_byte    = type_byte;
    view.prefix_match = prefix_match;
    view.line_found   = line_found;
    view.line_length  = line_length;
    saw_cr_next       = saw_cr;
    if (keep) begin
      if (byte_count < IdentPrefixBytes) begin
        if (data_byte != prefix_char) view.prefix_match = 1'b0;
        view.length_shift = {length_shift[23:0], data_byte};
      end else if (byte_count == 16'd4) begin
        view.pad_byte = data_byte;
      end else if (byte_count == 16'd5) begin
        view.type_byte = data_byte;
      end
      if (!line_found) begin
        if (saw_cr && data_byte == CHAR_LF) begin
          view.line_found  = 1'b1;
          view.line_length = byte_count - 16'd1;
        end
        saw_cr_next = (data_byte == CHAR_CR);
      end
      view.byte_count = byte_count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_capture)) begin
      byte_count   <= '0;
      length_shift <= '0;
      pad_byte     <= '0;
      type_byte    <= '0;
      prefix_match <= 1'b1;
      saw_cr       <= 1'b0;
      line_found   <= 1'b0;
      line_length  <= '0;
    end else if (take) begin
      byte_count   <= view.byte_count;
      length_shift <= view.length_shift;
      pad_byte     <= view.pad_byte;
      type_byte    <= view.type_byte;
      prefix_match <= view.prefix_match;
      saw_cr       <= saw_cr_next;
      line_found   <= view.line_found;
      line_length  <= view.line_length;
    end
  end

endmodule

// File: design/ssh_record_classifier.sv
// ----------------------------------------------------------------------------
// SSH record classifier
// Classifies one captured packet as an SSH identification line, an SSH
// binary packet header, or neither, and reports the parsed header fields.
// ----------------------------------------------------------------------------
// Feed the packet bytes from the SSH layer offset on the slave stream, one
// byte per beat, with s_tlast on the last captured byte. The block takes one
// byte every cycle while no result waits on m_tready; a byte passes an input
// register and the scanner; the classification of a packet is registered in
// the output register for the master stream, one result beat per packet and
// no beats for the other bytes. The output register stalls the whole path
// only while a result waits on m_tready. A packet opening with "SSH-" reports
// the length of its identification line up to the first CR LF (parse_error
// if none is found); otherwise the 32-bit big-endian packet length, padding
// length and message type are checked (length at least 2, padding at least 4
// and below length, 4 + length within the capture) and reported as a binary
// packet, or kind 0 when the checks fail. Bytes past MAX_CAPTURE_BYTES
// before the end mark are dropped and the packet is judged on the rest.
module ssh_record_classifier #(
  parameter int MAX_CAPTURE_BYTES = srcls_pkg::MaxCaptureBytesDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // data_byte
  input  logic                               s_tlast,  // end_of_capture
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // record_kind[1:0], parse_error[2], ident_length[18:3],
  // record_length[50:19], pad_length[58:51], msg_type[66:59],
  // body_length[98:67], bytes_consumed[114:99], zero fill[119:115]
  output logic [srcls_pkg::TdataWidth-1:0]   m_tdata
);
  import srcls_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  logic       out_valid;
  result_t    out_result;

  logic       advance;
  logic       take;
  scan_view_t view;

  // advance the pipeline whenever the result register is free or drained
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign take     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // hold the byte while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  srcls_scan #(
    .MAX_CAPTURE_BYTES(MAX_CAPTURE_BYTES)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (in_byte),
    .end_of_capture (in_last),
    .view           (view)
  );

  // only the end-marked byte produces a result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      out_result <= classify(view);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(TdataWidth - ResultWidth)'(0), out_result};

endmodule
